// File: sv/lsr_pkg.sv
// shared types, constants and state codes of the line segment rasterizer
package lsr_pkg;

  // grid size defaults
  localparam int unsigned COLS_DEFAULT = 64;
  localparam int unsigned ROWS_DEFAULT = 64;

  // field widths
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned SYMBOL_W = 8;

  // one segment word
  typedef struct packed {
    logic [COORD_W-1:0]  start_col;
    logic [COORD_W-1:0]  start_row;
    logic [COORD_W-1:0]  end_col;
    logic [COORD_W-1:0]  end_row;
    logic [SYMBOL_W-1:0] symbol;
  } seg_t;

  // one pixel word
  typedef struct packed {
    logic [COORD_W-1:0]  pixel_col;
    logic [COORD_W-1:0]  pixel_row;
    logic [SYMBOL_W-1:0] pixel_symbol;
    logic                last_pixel;
  } pixel_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN
  } lsr_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic setup;
    logic step;
  } lsr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic degenerate;
    logic at_last;
  } lsr_status_t;

endpackage

// File: sv/lsr_ctrl.sv
// controller state machine of the line segment rasterizer
module lsr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  lsr_pkg::lsr_status_t status_i,
  output lsr_pkg::lsr_cmd_t    cmd_o,
  output logic                 busy_o
);

  lsr_pkg::lsr_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsr_pkg::ST_IDLE: begin
        if (start_i) state_d = lsr_pkg::ST_LOAD;
      end
      lsr_pkg::ST_LOAD: begin
        state_d = status_i.degenerate ? lsr_pkg::ST_IDLE : lsr_pkg::ST_RUN;
      end
      lsr_pkg::ST_RUN: begin
        if (status_i.at_last) state_d = lsr_pkg::ST_IDLE;
      end
      default: state_d = lsr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      lsr_pkg::ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      lsr_pkg::ST_LOAD: begin
        cmd_o.setup = 1'b1;
      end
      lsr_pkg::ST_RUN: begin
        cmd_o.step = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

// File: sv/lsr_datapath.sv
// datapath of the line segment rasterizer: clamp, setup and remainder stepping
module lsr_datapath #(
  parameter int unsigned COLS = lsr_pkg::COLS_DEFAULT,
  parameter int unsigned ROWS = lsr_pkg::ROWS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsr_pkg::lsr_cmd_t    cmd_i,
  input  lsr_pkg::seg_t        seg_i,
  output lsr_pkg::lsr_status_t status_o,
  output logic                 pixel_valid_o,
  output lsr_pkg::pixel_t      pixel_o
);

  localparam int unsigned CW = lsr_pkg::COORD_W;
  localparam logic [CW-1:0] COL_MAX = CW'(COLS - 1);
  localparam logic [CW-1:0] ROW_MAX = CW'(ROWS - 1);

  // captured, clamped segment
  logic [CW-1:0]               c1_q, r1_q, c2_q, r2_q;
  logic [lsr_pkg::SYMBOL_W-1:0] sym_q;

  // stepping state
  logic                col_major_q, col_major_d;
  logic [CW-1:0]       maj_q, maj_d;
  logic [CW-1:0]       hi_q, hi_d;
  logic [CW-1:0]       min_q, min_d;
  logic [CW-1:0]       span_q, span_d;
  logic signed [CW:0]  slope_q, slope_d;
  logic [CW-1:0]       rem_q, rem_d;

  // output word
  logic            valid_q;
  lsr_pkg::pixel_t pix_q;

  // clamp and capture on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      c1_q  <= (seg_i.start_col > COL_MAX) ? COL_MAX : seg_i.start_col;
      r1_q  <= (seg_i.start_row > ROW_MAX) ? ROW_MAX : seg_i.start_row;
      c2_q  <= (seg_i.end_col > COL_MAX) ? COL_MAX : seg_i.end_col;
      r2_q  <= (seg_i.end_row > ROW_MAX) ? ROW_MAX : seg_i.end_row;
      sym_q <= seg_i.symbol;
    end
  end

  // setup: spans, major axis, walk from the low end of the major axis
  logic signed [CW+1:0] dc, dr, ndc, ndr;
  logic [CW-1:0]        adc, adr, maj1, maj2, min1, min2, lo, min_lo, min_hi;
  logic                 col_major, dir_up;

  always_comb begin
    dc        = $signed({2'b00, c2_q}) - $signed({2'b00, c1_q});
    dr        = $signed({2'b00, r2_q}) - $signed({2'b00, r1_q});
    ndc       = -dc;
    ndr       = -dr;
    adc       = dc[CW+1] ? ndc[CW-1:0] : dc[CW-1:0];
    adr       = dr[CW+1] ? ndr[CW-1:0] : dr[CW-1:0];
    col_major = adc > adr;
    maj1      = col_major ? c1_q : r1_q;
    maj2      = col_major ? c2_q : r2_q;
    min1      = col_major ? r1_q : c1_q;
    min2      = col_major ? r2_q : c2_q;
    dir_up    = maj1 < maj2;
    lo        = dir_up ? maj1 : maj2;
    hi_d      = dir_up ? maj2 : maj1;
    min_lo    = dir_up ? min1 : min2;
    min_hi    = dir_up ? min2 : min1;
    span_d    = hi_d - lo;
    slope_d   = $signed({1'b0, min_hi}) - $signed({1'b0, min_lo});
    col_major_d = col_major;
  end

  // one step: keep minor = ceil(num / span) with num = minor * span - rem
  logic signed [CW+1:0] rem_t;
  logic                 wrap_up, wrap_dn;

  always_comb begin
    rem_t   = $signed({2'b00, rem_q}) - $signed({slope_q[CW], slope_q});
    wrap_up = !slope_q[CW] && rem_t[CW+1];
    wrap_dn = slope_q[CW] && (rem_t >= $signed({2'b00, span_q}));
    maj_d   = maj_q + CW'(1);
    priority if (wrap_up) begin
      rem_d = rem_t[CW-1:0] + span_q;
      min_d = min_q + CW'(1);
    end else if (wrap_dn) begin
      rem_d = rem_t[CW-1:0] - span_q;
      min_d = min_q - CW'(1);
    end else begin
      rem_d = rem_t[CW-1:0];
      min_d = min_q;
    end
  end

  // stepping registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      col_major_q <= col_major_d;
      maj_q       <= lo;
      hi_q        <= hi_d;
      min_q       <= min_lo;
      span_q      <= span_d;
      slope_q     <= slope_d;
      rem_q       <= '0;
    end else if (cmd_i.step) begin
      maj_q <= maj_d;
      min_q <= min_d;
      rem_q <= rem_d;
    end
  end

  // output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.step;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pix_q.pixel_col    <= col_major_q ? maj_q : min_q;
      pix_q.pixel_row    <= col_major_q ? min_q : maj_q;
      pix_q.pixel_symbol <= sym_q;
      pix_q.last_pixel   <= (maj_q == hi_q);
    end
  end

  // status to controller
  assign status_o.degenerate = (adc == '0) && (adr == '0);
  assign status_o.at_last    = (maj_q == hi_q);

  assign pixel_valid_o = valid_q;
  assign pixel_o       = pix_q;

endmodule

// File: sv/line_segment_rasterizer_unit.sv
// top level of the line segment rasterizer
// A segment word is taken when start_i is high and busy_o is low. The unit
// clamps both endpoints to the grid, picks the major axis (columns only when
// the column span is strictly larger) and emits one pixel word per cycle on
// pixel_valid_o, from the low end of the major axis to the high end; the
// last one carries last_pixel. Pixels cannot be held off: the receiver must
// take each word in the cycle it is shown. After acceptance the unit passes
// through its load state and then steps once per pixel, each pixel word
// registered from its step; a segment with a major span of S gives S + 1
// pixel words and holds busy_o high through the load state and all steps,
// and a segment with equal endpoints gives no pixels and holds busy_o only
// for the load state. The rate is set by the remainder stepping unit, which
// produces one pixel per cycle with exact ceiling rounding.
module line_segment_rasterizer_unit #(
  parameter int unsigned COLS = lsr_pkg::COLS_DEFAULT,
  parameter int unsigned ROWS = lsr_pkg::ROWS_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  lsr_pkg::seg_t   seg_i,
  output logic            pixel_valid_o,
  output lsr_pkg::pixel_t pixel_o
);

  lsr_pkg::lsr_cmd_t    cmd;
  lsr_pkg::lsr_status_t status;

  // controller
  lsr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // datapath
  lsr_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .seg_i         (seg_i),
    .status_o      (status),
    .pixel_valid_o (pixel_valid_o),
    .pixel_o       (pixel_o)
  );

  // an accepted segment makes the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("unit not busy after accepting a segment");

  // pixels only come out of a busy unit
  a_pixel_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o |-> $past(busy_o))
    else $error("pixel word without a segment in work");

  // pixels of a segment are back to back until the last one
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_valid_o && !pixel_o.last_pixel) |=> pixel_valid_o)
    else $error("gap inside a segment's pixel stream");

  // nothing follows the last pixel directly
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_valid_o && pixel_o.last_pixel) |=> !pixel_valid_o)
    else $error("pixel word right after the last pixel");

endmodule

// File: verif/line_segment_rasterizer_unit_test.sv
// self-checking testbench for the line segment rasterizer unit
`timescale 1ns / 1ps

module line_segment_rasterizer_unit_test;

  // cycles with no accepted segment and no pixel word before the run is declared hung
  localparam int WATCHDOG_LIMIT = 1000;
  // worst-case drain after the last pixel, from the unit's busy span
  localparam int DRAIN_CYCLES   = 70;
  localparam int RANDOM_ITEMS   = 258;
  localparam int MAX_PRINTED    = 40;

  // expected pixel words, predicted per accepted segment and checked in order
  class raster_scoreboard;
    lsr_pkg::pixel_t pending_pixels[$];
    int              mismatch_count;
    int              checked_pixels;
    int              segment_count;
    int              degenerate_count;

    function new();
      mismatch_count   = 0;
      checked_pixels   = 0;
      segment_count    = 0;
      degenerate_count = 0;
    endfunction

    // endpoints beyond the grid saturate to its last line
    function int clip_coord(logic [lsr_pkg::COORD_W-1:0] v, int unsigned lines);
      if (int'(v) > int'(lines) - 1) return int'(lines) - 1;
      return int'(v);
    endfunction

    // exact ceiling of num / den, den nonzero
    function int ceil_quot(int num, int den);
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (num >= 0) return (num + den - 1) / den;
      return -((-num) / den);
    endfunction

    // walk the major axis low to high and queue one pixel word per step
    function void note_segment(lsr_pkg::seg_t s);
      int              c1, r1, c2, r2, dc, dr, adc, adr, lo, hi, m, col, row, n;
      bit              col_major;
      lsr_pkg::pixel_t px;
      c1 = clip_coord(s.start_col, lsr_pkg::COLS_DEFAULT);
      r1 = clip_coord(s.start_row, lsr_pkg::ROWS_DEFAULT);
      c2 = clip_coord(s.end_col, lsr_pkg::COLS_DEFAULT);
      r2 = clip_coord(s.end_row, lsr_pkg::ROWS_DEFAULT);
      dc = c2 - c1;
      dr = r2 - r1;
      adc = (dc < 0) ? -dc : dc;
      adr = (dr < 0) ? -dr : dr;
      segment_count++;
      // equal endpoints give no pixels
      if (adc == 0 && adr == 0) begin
        degenerate_count++;
        return;
      end
      // equal spans step along rows
      col_major = (adc > adr);
      if (col_major) begin
        lo = (c1 < c2) ? c1 : c2;
        hi = (c1 < c2) ? c2 : c1;
      end else begin
        lo = (r1 < r2) ? r1 : r2;
        hi = (r1 < r2) ? r2 : r1;
      end
      n = 0;
      for (m = lo; m <= hi && n < 64; m++) begin
        if (col_major) begin
          col = m;
          row = r1 + ceil_quot((m - c1) * dr, dc);
        end else begin
          row = m;
          col = c1 + ceil_quot((m - r1) * dc, dr);
        end
        px.pixel_col    = col[lsr_pkg::COORD_W-1:0];
        px.pixel_row    = row[lsr_pkg::COORD_W-1:0];
        px.pixel_symbol = s.symbol;
        px.last_pixel   = (m == hi);
        pending_pixels.push_back(px);
        n++;
      end
    endfunction

    task report_mismatch(string msg);
      if (mismatch_count < MAX_PRINTED) $display("mismatch: %s", msg);
      mismatch_count++;
    endtask

    // compare one shown pixel word against the oldest prediction
    task check_pixel(lsr_pkg::pixel_t got);
      lsr_pkg::pixel_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel word col %0d row %0d sym %0h",
                                  got.pixel_col, got.pixel_row, got.pixel_symbol));
        return;
      end
      want = pending_pixels.pop_front();
      checked_pixels++;
      if (got.pixel_col !== want.pixel_col)
        report_mismatch($sformatf("pixel_col got %0d want %0d",
                                  got.pixel_col, want.pixel_col));
      if (got.pixel_row !== want.pixel_row)
        report_mismatch($sformatf("pixel_row got %0d want %0d (col %0d)",
                                  got.pixel_row, want.pixel_row, want.pixel_col));
      if (got.pixel_symbol !== want.pixel_symbol)
        report_mismatch($sformatf("pixel_symbol got %0h want %0h",
                                  got.pixel_symbol, want.pixel_symbol));
      if (got.last_pixel !== want.last_pixel)
        report_mismatch($sformatf("last_pixel got %0b want %0b at col %0d row %0d",
                                  got.last_pixel, want.last_pixel,
                                  want.pixel_col, want.pixel_row));
    endtask
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            start_i;
  logic            busy_o;
  lsr_pkg::seg_t   seg_i;
  logic            pixel_valid_o;
  lsr_pkg::pixel_t pixel_o;

  raster_scoreboard sb;
  int               idle_cycles;

  line_segment_rasterizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .seg_i         (seg_i),
    .pixel_valid_o (pixel_valid_o),
    .pixel_o       (pixel_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // pixel monitor: every shown word is taken at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && pixel_valid_o) sb.check_pixel(pixel_o);
  end

  // watchdog on cycles without any accepted segment or shown pixel word
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || pixel_valid_o) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word accepted for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic lsr_pkg::seg_t make_seg(int c1, int r1, int c2, int r2, int sym);
    lsr_pkg::seg_t s;
    s.start_col = c1[lsr_pkg::COORD_W-1:0];
    s.start_row = r1[lsr_pkg::COORD_W-1:0];
    s.end_col   = c2[lsr_pkg::COORD_W-1:0];
    s.end_row   = r2[lsr_pkg::COORD_W-1:0];
    s.symbol    = sym[lsr_pkg::SYMBOL_W-1:0];
    return s;
  endfunction

  function automatic int fit_coord(int v);
    if (v < 0) return 0;
    if (v > 63) return 63;
    return v;
  endfunction

  // mostly short segments, some full-span, axis-aligned and degenerate ones
  function automatic lsr_pkg::seg_t random_seg();
    int pick, c1, r1, c2, r2, sym;
    pick = $urandom_range(0, 99);
    sym  = $urandom_range(0, 255);
    c1   = $urandom_range(0, 63);
    r1   = $urandom_range(0, 63);
    if (pick < 60) begin
      c2 = fit_coord(c1 + int'($urandom_range(0, 16)) - 8);
      r2 = fit_coord(r1 + int'($urandom_range(0, 16)) - 8);
    end else if (pick < 85) begin
      c2 = $urandom_range(0, 63);
      r2 = $urandom_range(0, 63);
    end else if (pick < 92) begin
      if ($urandom_range(0, 1)) begin
        c2 = c1;
        r2 = $urandom_range(0, 63);
      end else begin
        c2 = $urandom_range(0, 63);
        r2 = r1;
      end
    end else begin
      c2 = c1;
      r2 = r1;
    end
    return make_seg(c1, r1, c2, r2, sym);
  endfunction

  // hold start until the unit takes the word
  task automatic send_segment(lsr_pkg::seg_t s);
    start_i <= 1'b1;
    seg_i   <= s;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_segment(s);
  endtask

  // sender gap: many back-to-back, mostly short, a few long
  task automatic sender_gap(bit calm);
    int pick, gap;
    pick = $urandom_range(0, 99);
    if (calm || pick < 45) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    lsr_pkg::seg_t directed[$];
    int            i;
    sb          = new();
    idle_cycles = 0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    seg_i       = '0;

    // degenerate, axis-aligned full spans, equal spans, near-equal spans
    directed.push_back(make_seg(0, 0, 0, 0, 8'h00));
    directed.push_back(make_seg(63, 63, 63, 63, 8'hff));
    directed.push_back(make_seg(0, 5, 63, 5, 8'hff));
    directed.push_back(make_seg(63, 58, 0, 58, 8'h00));
    directed.push_back(make_seg(5, 0, 5, 63, 8'haa));
    directed.push_back(make_seg(58, 63, 58, 0, 8'h55));
    directed.push_back(make_seg(17, 40, 17, 40, 8'h5a));
    directed.push_back(make_seg(0, 0, 63, 63, 8'h01));
    directed.push_back(make_seg(63, 0, 0, 63, 8'h80));
    directed.push_back(make_seg(0, 63, 63, 0, 8'h7f));
    directed.push_back(make_seg(63, 63, 0, 0, 8'hfe));
    directed.push_back(make_seg(0, 0, 63, 62, 8'h3c));
    directed.push_back(make_seg(63, 62, 0, 0, 8'hc3));
    directed.push_back(make_seg(0, 0, 62, 63, 8'h0f));
    directed.push_back(make_seg(62, 63, 0, 0, 8'hf0));
    directed.push_back(make_seg(0, 0, 63, 1, 8'h11));
    directed.push_back(make_seg(0, 0, 1, 63, 8'h22));
    // single steps in each direction
    directed.push_back(make_seg(10, 10, 11, 10, 8'h33));
    directed.push_back(make_seg(10, 10, 10, 11, 8'h44));
    directed.push_back(make_seg(10, 10, 11, 11, 8'h66));
    directed.push_back(make_seg(11, 11, 10, 10, 8'h77));
    // negative slopes with uneven ratios
    directed.push_back(make_seg(0, 40, 50, 10, 8'h99));
    directed.push_back(make_seg(50, 10, 0, 40, 8'hbb));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      send_segment(directed[k]);
      sender_gap(1'b0);
    end

    // random part, with stretches where the sender never pauses
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      send_segment(random_seg());
      sender_gap((i / 32) % 3 == 1);
    end
    start_i <= 1'b0;

    // drain
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending_pixels.size() != 0)
      sb.report_mismatch($sformatf("%0d pixel words never shown",
                                   sb.pending_pixels.size()));

    $display("covered %0d segments (%0d degenerate), %0d pixel words checked",
             sb.segment_count, sb.degenerate_count, sb.checked_pixels);
    $display("mismatches: %0d", sb.mismatch_count);
    if (sb.mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
